// ===== rtl/lslf_pkg.sv =====
// Shared types and constants for the least-squares line fit block.
// Used by the controller, the datapath and the top level; no dependencies.
package lslf_pkg;

   localparam int MaxPointsDefault  = 1024;
   localparam int SampleBitsDefault = 16;
   localparam int InBits            = 16;
   localparam int OutBits           = 48;
   localparam int CountOutBits      = 11;
   localparam int StatusBits        = 2;
   localparam int FracBits          = 16;
   localparam int SelBits           = 3;

   localparam logic [SelBits-1:0] LastProduct  = 3'd5;

   typedef enum logic [StatusBits-1:0] {
      FIT_OK       = 2'd0,
      FIT_DEN_ZERO = 2'd1,
      FIT_OVERFLOW = 2'd2
   } fit_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MLOAD,
      S_MRUN,
      S_CHECK,
      S_DLOAD,
      S_DRUN,
      S_OUT
   } ctl_state_type;

   typedef struct packed {
      logic               accept;
      logic               mul_load;
      logic               mul_store;
      logic [SelBits-1:0] mul_sel;
      logic               div_load;
      logic               div_store;
      logic               div_sel;
      logic               clear;
   } lslf_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic div_done;
      logic den_zero;
   } lslf_stat_type;

endpackage

// ===== rtl/lslf_ctrl.sv =====
// Controller state machine for the line fit: accepts words, then sequences
// six products and, unless the denominator is zero, two divisions. Depends on lslf_pkg.
module lslf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    req_last_point,
   input  lslf_pkg::lslf_stat_type stat,
   output lslf_pkg::lslf_cmd_type  cmd,
   output logic                    busy,
   output logic                    rsp_valid
);
   import lslf_pkg::*;

   ctl_state_type      state_ff, state_in;
   logic [SelBits-1:0] k_ff, k_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      unique case (state_ff)
         S_IDLE: begin
            k_in = '0;
            if (start && req_last_point) begin
               state_in = S_MLOAD;
            end
         end
         S_MLOAD: begin
            state_in = S_MRUN;
         end
         S_MRUN: begin
            if (stat.mul_done) begin
               if (k_ff == LastProduct) begin
                  k_in     = '0;
                  state_in = S_CHECK;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_MLOAD;
               end
            end
         end
         S_CHECK: begin
            state_in = stat.den_zero ? S_OUT : S_DLOAD;
         end
         S_DLOAD: begin
            state_in = S_DRUN;
         end
         S_DRUN: begin
            if (stat.div_done) begin
               if (k_ff[0]) begin
                  state_in = S_OUT;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = S_DLOAD;
               end
            end
         end
         S_OUT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd           = '0;
      cmd.mul_sel   = k_ff;
      cmd.div_sel   = k_ff[0];
      busy          = 1'b1;
      rsp_valid     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            busy       = 1'b0;
            cmd.accept = start;
         end
         S_MLOAD: begin
            cmd.mul_load = 1'b1;
         end
         S_MRUN: begin
            cmd.mul_store = stat.mul_done;
         end
         S_CHECK: begin
         end
         S_DLOAD: begin
            cmd.div_load = 1'b1;
         end
         S_DRUN: begin
            cmd.div_store = stat.div_done;
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            cmd.clear = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/lslf_datapath.sv =====
// Datapath for the line fit: sum registers, a shift-add multiplier and a
// restoring divider with Q32.16 saturation. Depends on lslf_pkg.
module lslf_datapath #(
   parameter int MAX_POINTS  = lslf_pkg::MaxPointsDefault,
   parameter int SAMPLE_BITS = lslf_pkg::SampleBitsDefault
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  lslf_pkg::lslf_cmd_type                 cmd,
   input  logic signed [lslf_pkg::InBits-1:0]     req_x_value,
   input  logic signed [lslf_pkg::InBits-1:0]     req_y_value,
   output lslf_pkg::lslf_stat_type                stat,
   output logic signed [lslf_pkg::OutBits-1:0]    rsp_intercept,
   output logic signed [lslf_pkg::OutBits-1:0]    rsp_slope,
   output logic [lslf_pkg::CountOutBits-1:0]      rsp_point_count,
   output logic [lslf_pkg::StatusBits-1:0]        rsp_fit_status
);
   import lslf_pkg::*;

   localparam int CNT_W  = $clog2(MAX_POINTS + 1);
   localparam int SX_W   = SAMPLE_BITS + CNT_W;
   localparam int SQ_W   = 2 * SAMPLE_BITS + CNT_W;
   localparam int PW     = SX_W + SQ_W;
   localparam int NUM_W  = PW + 1;
   localparam int DIV_W  = NUM_W + FracBits;
   localparam int MCNT_W = $clog2(SX_W + 1);
   localparam int DCNT_W = $clog2(DIV_W + 1);

   localparam logic [OutBits-1:0] PosLimit = {1'b0, {(OutBits-1){1'b1}}};
   localparam logic [OutBits-1:0] NegLimit = {1'b1, {(OutBits-1){1'b0}}};

   logic [CNT_W-1:0]        count_ff, count_in;
   logic signed [SX_W-1:0]  sx_ff, sx_in, sy_ff, sy_in;
   logic signed [SQ_W-1:0]  sxx_ff, sxx_in, sxy_ff, sxy_in;
   logic                    ovf_ff, ovf_in;

   logic signed [SAMPLE_BITS-1:0]   xs, ys;
   logic signed [2*SAMPLE_BITS-1:0] xx, xy;

   assign xs = SAMPLE_BITS'($unsigned(req_x_value));
   assign ys = SAMPLE_BITS'($unsigned(req_y_value));
   assign xx = xs * xs;
   assign xy = xs * ys;

   always_comb begin
      count_in = count_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      sxx_in   = sxx_ff;
      sxy_in   = sxy_ff;
      ovf_in   = ovf_ff;
      if (cmd.clear) begin
         count_in = '0;
         sx_in    = '0;
         sy_in    = '0;
         sxx_in   = '0;
         sxy_in   = '0;
         ovf_in   = 1'b0;
      end else if (cmd.accept) begin
         if (count_ff < CNT_W'(MAX_POINTS)) begin
            count_in = count_ff + 1'b1;
            sx_in    = sx_ff + SX_W'(xs);
            sy_in    = sy_ff + SX_W'(ys);
            sxx_in   = sxx_ff + SQ_W'(xx);
            sxy_in   = sxy_ff + SQ_W'(xy);
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sx_ff    <= '0;
         sy_ff    <= '0;
         sxx_ff   <= '0;
         sxy_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         sx_ff    <= sx_in;
         sy_ff    <= sy_in;
         sxx_ff   <= sxx_in;
         sxy_ff   <= sxy_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Shift-add multiplier on magnitudes, one multiplier bit per cycle.
   logic signed [SQ_W-1:0] a_op;
   logic signed [SX_W-1:0] b_op, n_op;
   logic [SQ_W-1:0]        a_mag;
   logic [SX_W-1:0]        b_mag;
   logic [PW-1:0]          mcand_ff, mcand_in, macc_ff, macc_in;
   logic [SX_W-1:0]        mplier_ff, mplier_in;
   logic                   mneg_ff, mneg_in;
   logic [MCNT_W-1:0]      mcnt_ff, mcnt_in;
   logic signed [PW-1:0]   prod;
   logic signed [NUM_W-1:0] den_ff, den_in, pn_ff, pn_in, qn_ff, qn_in;

   assign n_op = SX_W'(count_ff);

   always_comb begin
      case (cmd.mul_sel)
         3'd0: begin a_op = sxx_ff;       b_op = n_op;  end
         3'd1: begin a_op = SQ_W'(sx_ff); b_op = sx_ff; end
         3'd2: begin a_op = sxx_ff;       b_op = sy_ff; end
         3'd3: begin a_op = sxy_ff;       b_op = sx_ff; end
         3'd4: begin a_op = sxy_ff;       b_op = n_op;  end
         default: begin a_op = SQ_W'(sy_ff); b_op = sx_ff; end
      endcase
   end

   assign a_mag = a_op[SQ_W-1] ? $unsigned(-a_op) : $unsigned(a_op);
   assign b_mag = b_op[SX_W-1] ? $unsigned(-b_op) : $unsigned(b_op);
   assign prod  = mneg_ff ? -$signed(macc_ff) : $signed(macc_ff);

   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      macc_in   = macc_ff;
      mneg_in   = mneg_ff;
      mcnt_in   = mcnt_ff;
      if (cmd.mul_load) begin
         mcand_in  = PW'(a_mag);
         mplier_in = b_mag;
         macc_in   = '0;
         mneg_in   = a_op[SQ_W-1] ^ b_op[SX_W-1];
         mcnt_in   = MCNT_W'(SX_W);
      end else if (mcnt_ff != '0) begin
         if (mplier_ff[0]) begin
            macc_in = macc_ff + mcand_ff;
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         mcnt_in   = mcnt_ff - 1'b1;
      end
   end

   always_comb begin
      den_in = den_ff;
      pn_in  = pn_ff;
      qn_in  = qn_ff;
      if (cmd.mul_store) begin
         case (cmd.mul_sel)
            3'd0:    den_in = NUM_W'(prod);
            3'd1:    den_in = den_ff - NUM_W'(prod);
            3'd2:    pn_in  = NUM_W'(prod);
            3'd3:    pn_in  = pn_ff - NUM_W'(prod);
            3'd4:    qn_in  = NUM_W'(prod);
            default: qn_in  = qn_ff - NUM_W'(prod);
         endcase
      end
   end

   // Restoring divider: one quotient bit per cycle, quotient kept to the
   // output width with a sticky flag for any bit above it.
   logic signed [NUM_W-1:0] num_op;
   logic [NUM_W-1:0]        nmag, dmag;
   logic [DIV_W-1:0]        dsh_ff, dsh_in;
   logic [NUM_W-1:0]        rem_ff, rem_in, dvs_ff, dvs_in;
   logic [NUM_W:0]          trial;
   logic                    ge;
   logic [OutBits-1:0]      quo_ff, quo_in, limit, qmag, qres;
   logic                    qovf_ff, qovf_in, dneg_ff, dneg_in;
   logic [DCNT_W-1:0]       dcnt_ff, dcnt_in;
   logic [OutBits-1:0]      p_ff, p_in, q_ff, q_in;

   assign num_op = cmd.div_sel ? qn_ff : pn_ff;
   assign nmag   = num_op[NUM_W-1] ? $unsigned(-num_op) : $unsigned(num_op);
   assign dmag   = den_ff[NUM_W-1] ? $unsigned(-den_ff) : $unsigned(den_ff);
   assign trial  = {rem_ff, dsh_ff[DIV_W-1]};
   assign ge     = trial >= {1'b0, dvs_ff};
   assign limit  = dneg_ff ? NegLimit : PosLimit;
   assign qmag   = (qovf_ff || quo_ff > limit) ? limit : quo_ff;
   assign qres   = dneg_ff ? -qmag : qmag;

   always_comb begin
      dsh_in  = dsh_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      qovf_in = qovf_ff;
      dneg_in = dneg_ff;
      dcnt_in = dcnt_ff;
      p_in    = p_ff;
      q_in    = q_ff;
      if (cmd.div_load) begin
         dsh_in  = {nmag, {FracBits{1'b0}}};
         rem_in  = '0;
         dvs_in  = dmag;
         quo_in  = '0;
         qovf_in = 1'b0;
         dneg_in = num_op[NUM_W-1] ^ den_ff[NUM_W-1];
         dcnt_in = DCNT_W'(DIV_W);
      end else if (dcnt_ff != '0) begin
         rem_in  = ge ? NUM_W'(trial - {1'b0, dvs_ff}) : NUM_W'(trial);
         dsh_in  = dsh_ff << 1;
         quo_in  = {quo_ff[OutBits-2:0], ge};
         qovf_in = qovf_ff | quo_ff[OutBits-1];
         dcnt_in = dcnt_ff - 1'b1;
      end
      if (cmd.div_store) begin
         if (cmd.div_sel) begin
            q_in = qres;
         end else begin
            p_in = qres;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mcnt_ff <= '0;
         dcnt_ff <= '0;
      end else begin
         mcnt_ff <= mcnt_in;
         dcnt_ff <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      macc_ff   <= macc_in;
      mneg_ff   <= mneg_in;
      den_ff    <= den_in;
      pn_ff     <= pn_in;
      qn_ff     <= qn_in;
      dsh_ff    <= dsh_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      quo_ff    <= quo_in;
      qovf_ff   <= qovf_in;
      dneg_ff   <= dneg_in;
      p_ff      <= p_in;
      q_ff      <= q_in;
   end

   assign stat.mul_done = (mcnt_ff == '0);
   assign stat.div_done = (dcnt_ff == '0);
   assign stat.den_zero = (den_ff == '0);

   assign rsp_intercept   = stat.den_zero ? '0 : $signed(p_ff);
   assign rsp_slope       = stat.den_zero ? '0 : $signed(q_ff);
   assign rsp_point_count = CountOutBits'(count_ff);
   assign rsp_fit_status  = stat.den_zero ? FIT_DEN_ZERO :
                            (ovf_ff ? FIT_OVERFLOW : FIT_OK);

endmodule

// ===== rtl/least_squares_line_fit.sv =====
// Least-squares line fit, top level: controller plus datapath, uses lslf_pkg.
// Ordinary points are taken one a cycle; busy stays low between them.
// After the last point, the controller runs six shift-add products over
// SX = SAMPLE_BITS + clog2(MAX_POINTS+1) multiplier bits, then two restoring
// divisions over DW = SX + 2*SAMPLE_BITS + clog2(MAX_POINTS+1) + 17 dividend bits
// before the result strobe. A zero denominator skips the divider. Reset clears all sums; no stall.
module least_squares_line_fit #(
   parameter int MAX_POINTS  = lslf_pkg::MaxPointsDefault,
   parameter int SAMPLE_BITS = lslf_pkg::SampleBitsDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [lslf_pkg::InBits-1:0]  req_x_value,
   input  logic signed [lslf_pkg::InBits-1:0]  req_y_value,
   input  logic                                req_last_point,
   output logic                                rsp_valid,
   output logic signed [lslf_pkg::OutBits-1:0] rsp_intercept,
   output logic signed [lslf_pkg::OutBits-1:0] rsp_slope,
   output logic [lslf_pkg::CountOutBits-1:0]   rsp_point_count,
   output logic [lslf_pkg::StatusBits-1:0]     rsp_fit_status
);
   import lslf_pkg::*;

   lslf_cmd_type  cmd;
   lslf_stat_type stat;

   lslf_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_last_point (req_last_point),
      .stat           (stat),
      .cmd            (cmd),
      .busy           (busy),
      .rsp_valid      (rsp_valid)
   );

   lslf_datapath #(
      .MAX_POINTS  (MAX_POINTS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_x_value     (req_x_value),
      .req_y_value     (req_y_value),
      .stat            (stat),
      .rsp_intercept   (rsp_intercept),
      .rsp_slope       (rsp_slope),
      .rsp_point_count (rsp_point_count),
      .rsp_fit_status  (rsp_fit_status)
   );

endmodule
